### hdl/wsd_pkg.sv
// Shared types and constants for the frame deframer.
package wsd_pkg;

  localparam logic [6:0] LEN_CODE_16 = 7'd126;
  localparam logic [6:0] LEN_CODE_64 = 7'd127;
  localparam logic [2:0] EXT16_COUNT = 3'd1;
  localparam logic [2:0] EXT64_COUNT = 3'd7;
  localparam logic [2:0] KEY_COUNT   = 3'd3;

  typedef enum logic [2:0] {
    PH_HDR0    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXTLEN  = 3'd2,
    PH_KEY     = 3'd3,
    PH_PAYLOAD = 3'd4
  } phase_t;

  typedef struct packed {
    logic [7:0]  payload_byte;
    logic [3:0]  frame_opcode;
    logic        final_fragment;
    logic        frame_last;
    logic        message_last;
    logic        empty_frame;
    logic [63:0] frame_length;
  } res_t;

  typedef struct packed {
    logic in_payload;
    logic left_zero;
  } stat_t;

endpackage

### hdl/wsd_if.sv
// Channel interfaces: received byte stream and deframed results.
interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source(output valid, output data_byte, input ready);
  modport sink(input valid, input data_byte, output ready);
endinterface

interface wsd_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  payload_byte;
  logic [3:0]  frame_opcode;
  logic        final_fragment;
  logic        frame_last;
  logic        message_last;
  logic        empty_frame;
  logic [63:0] frame_length;
  modport source(output valid, output payload_byte, output frame_opcode,
                 output final_fragment, output frame_last, output message_last,
                 output empty_frame, output frame_length, input ready);
  modport sink(input valid, input payload_byte, input frame_opcode,
               input final_fragment, input frame_last, input message_last,
               input empty_frame, input frame_length, output ready);
endinterface

### hdl/wsd_stage_in.sv
// Input register for the received byte stream.
module wsd_stage_in (
  input  logic       clk,
  input  logic       rst,
  wsd_in_if.sink     stream,
  input  logic       advance,
  output logic       byte_valid,
  output logic [7:0] byte_q
);

  assign stream.ready = !byte_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid <= 1'b0;
    end else if (stream.valid && stream.ready) begin
      byte_valid <= 1'b1;
    end else if (advance) begin
      byte_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (stream.valid && stream.ready) begin
      byte_q <= stream.data_byte;
    end
  end

endmodule

### hdl/wsd_parser.sv
// Frame header parser, payload unmasking and frame state.
module wsd_parser (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic [7:0]    data_byte,
  output wsd_pkg::res_t res,
  output logic          res_valid,
  output wsd_pkg::stat_t stat
);
  import wsd_pkg::*;

  phase_t      phase, phase_next;
  logic        fin, fin_next;
  logic [3:0]  opcode, opcode_next;
  logic        masked, masked_next;
  logic [63:0] length, length_next;
  logic [63:0] bytes_left, bytes_left_next;
  logic [2:0]  fcount, fcount_next;
  logic [31:0] key, key_next;
  logic [1:0]  kidx, kidx_next;
  logic        hdr_done;
  logic        flast;
  logic [7:0]  key_byte;

  always_ff @(posedge clk) begin
    if (rst) begin
      phase      <= PH_HDR0;
      fin        <= 1'b0;
      opcode     <= 4'd0;
      masked     <= 1'b0;
      length     <= 64'd0;
      bytes_left <= 64'd0;
      fcount     <= 3'd0;
      key        <= 32'd0;
      kidx       <= 2'd0;
    end else if (take) begin
      phase      <= phase_next;
      fin        <= fin_next;
      opcode     <= opcode_next;
      masked     <= masked_next;
      length     <= length_next;
      bytes_left <= bytes_left_next;
      fcount     <= fcount_next;
      key        <= key_next;
      kidx       <= kidx_next;
    end
  end

  assign key_byte = key[{~kidx, 3'b000} +: 8];
  assign flast    = (bytes_left == 64'd1);

  always_comb begin
    phase_next      = phase;
    fin_next        = fin;
    opcode_next     = opcode;
    masked_next     = masked;
    length_next     = length;
    bytes_left_next = bytes_left;
    fcount_next     = fcount;
    key_next        = key;
    kidx_next       = kidx;
    hdr_done        = 1'b0;
    res_valid       = 1'b0;
    res.payload_byte = 8'd0;
    res.frame_last   = 1'b0;
    res.empty_frame  = 1'b0;

    unique case (phase)
      PH_HDR1: begin
        masked_next = data_byte[7];
        key_next    = 32'd0;
        length_next = 64'd0;
        if (data_byte[6:0] == LEN_CODE_16) begin
          fcount_next = EXT16_COUNT;
          phase_next  = PH_EXTLEN;
        end else if (data_byte[6:0] == LEN_CODE_64) begin
          fcount_next = EXT64_COUNT;
          phase_next  = PH_EXTLEN;
        end else begin
          length_next = {57'd0, data_byte[6:0]};
          if (data_byte[7]) begin
            fcount_next = KEY_COUNT;
            phase_next  = PH_KEY;
          end else begin
            hdr_done = 1'b1;
          end
        end
      end
      PH_EXTLEN: begin
        length_next = {length[55:0], data_byte};
        if (fcount == 3'd0) begin
          if (masked) begin
            fcount_next = KEY_COUNT;
            phase_next  = PH_KEY;
          end else begin
            hdr_done = 1'b1;
          end
        end else begin
          fcount_next = fcount - 3'd1;
        end
      end
      PH_KEY: begin
        key_next = {key[23:0], data_byte};
        if (fcount == 3'd0) begin
          hdr_done = 1'b1;
        end else begin
          fcount_next = fcount - 3'd1;
        end
      end
      PH_PAYLOAD: begin
        bytes_left_next  = bytes_left - 64'd1;
        kidx_next        = kidx + 2'd1;
        res_valid        = 1'b1;
        res.payload_byte = data_byte ^ key_byte;
        res.frame_last   = flast;
        if (flast) begin
          phase_next = PH_HDR0;
        end
      end
      default: begin
        fin_next    = data_byte[7];
        opcode_next = data_byte[3:0];
        phase_next  = PH_HDR1;
      end
    endcase

    if (hdr_done) begin
      if (length_next == 64'd0) begin
        phase_next      = PH_HDR0;
        res_valid       = 1'b1;
        res.frame_last  = 1'b1;
        res.empty_frame = 1'b1;
      end else begin
        bytes_left_next = length_next;
        kidx_next       = 2'd0;
        phase_next      = PH_PAYLOAD;
      end
    end

    res.frame_opcode   = opcode;
    res.final_fragment = fin;
    res.message_last   = res.frame_last && fin;
    res.frame_length   = length_next;
  end

  assign stat.in_payload = (phase == PH_PAYLOAD);
  assign stat.left_zero  = (bytes_left == 64'd0);

endmodule

### hdl/wsd_result_reg.sv
// Result register driving the deframed output channel.
module wsd_result_reg (
  input  logic          clk,
  input  logic          rst,
  input  logic          take,
  input  logic          res_valid,
  input  wsd_pkg::res_t res,
  output logic          advance,
  wsd_out_if.source     frames
);
  import wsd_pkg::*;

  logic valid;
  res_t res_q;

  assign advance = !valid || frames.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (advance) begin
      valid <= take && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && take && res_valid) begin
      res_q <= res;
    end
  end

  assign frames.valid          = valid;
  assign frames.payload_byte   = res_q.payload_byte;
  assign frames.frame_opcode   = res_q.frame_opcode;
  assign frames.final_fragment = res_q.final_fragment;
  assign frames.frame_last     = res_q.frame_last;
  assign frames.message_last   = res_q.message_last;
  assign frames.empty_frame    = res_q.empty_frame;
  assign frames.frame_length   = res_q.frame_length;

endmodule

### hdl/websocket_frame_deframer.sv
// Top level of the frame deframer: input register, parser, result register.
// A payload byte, or the byte that closes a zero-length header, passes through
// the input register, the parser and the result register before its result shows.
// Throughput: one byte per cycle unless the output channel stalls, set by the parser step.
// Reset: rst clears the parse phase, frame state and both valid flags.
module websocket_frame_deframer (
  input  logic      clk,
  input  logic      rst,
  wsd_in_if.sink    stream,
  wsd_out_if.source frames
);
  import wsd_pkg::*;

  logic       advance;
  logic       byte_valid;
  logic [7:0] byte_q;
  logic       take;
  logic       res_valid;
  res_t       res;
  stat_t      stat;

  assign take = byte_valid && advance;

  wsd_stage_in u_stage_in (
    .clk        (clk),
    .rst        (rst),
    .stream     (stream),
    .advance    (advance),
    .byte_valid (byte_valid),
    .byte_q     (byte_q)
  );

  wsd_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .data_byte (byte_q),
    .res       (res),
    .res_valid (res_valid),
    .stat      (stat)
  );

  wsd_result_reg u_result_reg (
    .clk       (clk),
    .rst       (rst),
    .take      (take),
    .res_valid (res_valid),
    .res       (res),
    .advance   (advance),
    .frames    (frames)
  );

  a_payload_left: assert property (@(posedge clk) disable iff (rst)
    stat.in_payload |-> !stat.left_zero)
    else $error("payload phase with no bytes left");

  a_empty_marker: assert property (@(posedge clk) disable iff (rst)
    (frames.valid && frames.empty_frame) |->
      (frames.frame_last && frames.payload_byte == 8'd0 && frames.frame_length == 64'd0))
    else $error("malformed empty-frame marker");

  a_data_len: assert property (@(posedge clk) disable iff (rst)
    (frames.valid && !frames.empty_frame) |-> (frames.frame_length != 64'd0))
    else $error("payload result with zero frame length");

  a_msg_last: assert property (@(posedge clk) disable iff (rst)
    (frames.valid && frames.message_last) |-> (frames.frame_last && frames.final_fragment))
    else $error("message end outside a final frame end");

endmodule

### dv/websocket_frame_deframer_test.sv
// Self-checking testbench for the frame deframer with random stalls and a reference predictor.
`timescale 1ns / 1ps

module websocket_frame_deframer_test;
  import wsd_pkg::*;

  typedef enum logic [1:0] {LEN_DIRECT, LEN_EXT16, LEN_EXT64} len_form_t;
  typedef enum logic [3:0] {
    OP_CONT   = 4'd0,
    OP_TEXT   = 4'd1,
    OP_BINARY = 4'd2,
    OP_CLOSE  = 4'd8,
    OP_PING   = 4'd9,
    OP_PONG   = 4'd10
  } opcode_t;

  logic clk;
  logic rst;

  wsd_in_if  stream();
  wsd_out_if frames();

  websocket_frame_deframer i_dut (
    .clk    (clk),
    .rst    (rst),
    .stream (stream),
    .frames (frames)
  );

  logic [7:0] tx_bytes [$];
  res_t       expected_results [$];
  int         mismatches;
  int         results_seen;

  phase_t      frm_phase;
  logic        frm_fin;
  logic [3:0]  frm_opcode;
  logic        frm_masked;
  logic [63:0] frm_length;
  logic [63:0] frm_left;
  logic [2:0]  frm_count;
  logic [31:0] frm_key;
  logic [1:0]  frm_key_idx;

  logic byte_taken;
  logic result_taken;
  int   tx_gap;
  int   rx_stall;
  int   hold_left;
  logic held;
  logic in_burst;
  logic out_burst;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void add_byte(logic [7:0] b);
    tx_bytes.insert(tx_bytes.size(), b);
  endfunction

  function automatic void add_result(logic [7:0] pb, logic flast, logic empty);
    res_t r;
    r.payload_byte   = pb;
    r.frame_opcode   = frm_opcode;
    r.final_fragment = frm_fin;
    r.frame_last     = flast;
    r.message_last   = flast & frm_fin;
    r.empty_frame    = empty;
    r.frame_length   = frm_length;
    expected_results.insert(expected_results.size(), r);
  endfunction

  function automatic void finish_header();
    if (frm_length == 64'd0) begin
      frm_phase = PH_HDR0;
      add_result(8'd0, 1'b1, 1'b1);
    end else begin
      frm_left    = frm_length;
      frm_key_idx = 2'd0;
      frm_phase   = PH_PAYLOAD;
    end
  endfunction

  function automatic void finish_length();
    if (frm_masked) begin
      frm_count = KEY_COUNT;
      frm_phase = PH_KEY;
    end else begin
      finish_header();
    end
  endfunction

  function automatic void deframe_byte(logic [7:0] b);
    logic [7:0] kb;
    case (frm_phase)
      PH_HDR1: begin
        frm_masked = b[7];
        frm_key    = 32'd0;
        frm_length = 64'd0;
        if (b[6:0] < LEN_CODE_16) begin
          frm_length = {57'd0, b[6:0]};
          finish_length();
        end else begin
          frm_count = (b[6:0] == LEN_CODE_16) ? EXT16_COUNT : EXT64_COUNT;
          frm_phase = PH_EXTLEN;
        end
      end
      PH_EXTLEN: begin
        frm_length = {frm_length[55:0], b};
        if (frm_count == 3'd0) finish_length();
        else frm_count = frm_count - 3'd1;
      end
      PH_KEY: begin
        frm_key = {frm_key[23:0], b};
        if (frm_count == 3'd0) finish_header();
        else frm_count = frm_count - 3'd1;
      end
      PH_PAYLOAD: begin
        kb          = frm_key[8 * (3 - frm_key_idx) +: 8];
        frm_left    = frm_left - 64'd1;
        frm_key_idx = frm_key_idx + 2'd1;
        if (frm_left == 64'd0) frm_phase = PH_HDR0;
        add_result(b ^ kb, frm_left == 64'd0, 1'b0);
      end
      default: begin
        frm_fin    = b[7];
        frm_opcode = b[3:0];
        frm_phase  = PH_HDR1;
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, exp_v, act_v);
      mismatches++;
    end
  endfunction

  task automatic add_frame(input logic fin, input logic [2:0] rsv, input logic [3:0] op,
                           input logic masked, input len_form_t form, input logic [63:0] len,
                           input int body, input logic noisy);
    logic [31:0] key;
    logic [7:0]  b;
    key = $urandom;
    add_byte({fin, rsv, op});
    case (form)
      LEN_DIRECT: add_byte({masked, len[6:0]});
      LEN_EXT16: begin
        add_byte({masked, LEN_CODE_16});
        add_byte(len[15:8]);
        add_byte(len[7:0]);
      end
      default: begin
        add_byte({masked, LEN_CODE_64});
        for (int i = 7; i >= 0; i--) add_byte(len[8 * i +: 8]);
      end
    endcase
    if (masked) for (int i = 3; i >= 0; i--) add_byte(key[8 * i +: 8]);
    for (int i = 0; i < body; i++) begin
      b = 8'($urandom);
      if (noisy && b[0]) b = {b[7], 6'h3F, b[1]};
      add_byte(b);
    end
  endtask

  always @(posedge clk) begin : observe
    res_t exp_r;
    if (!rst) begin
      if (stream.valid && stream.ready) begin
        deframe_byte(stream.data_byte);
        byte_taken = 1'b1;
      end
      if (frames.valid && frames.ready) begin
        result_taken = 1'b1;
        results_seen++;
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual byte %0h length %0h",
                   $time, frames.payload_byte, frames.frame_length);
          mismatches++;
        end else begin
          exp_r = expected_results.pop_front();
          check_field("payload_byte", 64'(exp_r.payload_byte), 64'(frames.payload_byte));
          check_field("frame_opcode", 64'(exp_r.frame_opcode), 64'(frames.frame_opcode));
          check_field("final_fragment", 64'(exp_r.final_fragment),
                      64'(frames.final_fragment));
          check_field("frame_last", 64'(exp_r.frame_last), 64'(frames.frame_last));
          check_field("message_last", 64'(exp_r.message_last), 64'(frames.message_last));
          check_field("empty_frame", 64'(exp_r.empty_frame), 64'(frames.empty_frame));
          check_field("frame_length", exp_r.frame_length, frames.frame_length);
        end
      end
    end
  end

  always @(negedge clk) begin : drive
    logic nv;
    if (!rst) begin
      nv = stream.valid;
      if (byte_taken) begin
        nv         = 1'b0;
        byte_taken = 1'b0;
        tx_gap     = in_burst ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 63) == 0) in_burst = !in_burst;
      end
      if (!nv) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (tx_bytes.size() > 0) begin
          stream.data_byte <= tx_bytes.pop_front();
          nv = 1'b1;
        end
      end
      stream.valid <= nv;
    end
  end

  always @(negedge clk) begin : accept
    if (!rst) begin
      if (result_taken) begin
        result_taken = 1'b0;
        rx_stall     = out_burst ? 0 : $urandom_range(0, 7);
        if ($urandom_range(0, 63) == 0) out_burst = !out_burst;
      end
      if (!held && results_seen >= 400) begin
        held      = 1'b1;
        hold_left = 300;
      end
      if (hold_left > 0) begin
        hold_left--;
        frames.ready <= 1'b0;
      end else if (rx_stall > 0) begin
        rx_stall--;
        frames.ready <= 1'b0;
      end else begin
        frames.ready <= 1'b1;
      end
    end
  end

  initial begin
    #5_000_000;
    $display("tb: failure");
    $finish;
  end

  initial begin
    logic [7:0]  directed [25] = '{
      8'h81, 8'h00,
      8'h7F, 8'hFE, 8'h00, 8'h00, 8'hDE, 8'hAD, 8'hBE, 8'hEF,
      8'h88, 8'h7F, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h05,
      8'h00, 8'hFF, 8'h80, 8'h7F, 8'h55
    };
    logic        noisy;
    logic [3:0]  op;
    len_form_t   form;
    logic [63:0] len;
    int          sel;

    rst              = 1'b1;
    stream.valid     = 1'b0;
    stream.data_byte = 8'd0;
    frames.ready     = 1'b0;
    mismatches       = 0;
    results_seen     = 0;
    frm_phase        = PH_HDR0;
    frm_fin          = 1'b0;
    frm_opcode       = 4'd0;
    frm_masked       = 1'b0;
    frm_length       = 64'd0;
    frm_left         = 64'd0;
    frm_count        = 3'd0;
    frm_key          = 32'd0;
    frm_key_idx      = 2'd0;
    byte_taken       = 1'b0;
    result_taken     = 1'b0;
    tx_gap           = 0;
    rx_stall         = 0;
    hold_left        = 0;
    held             = 1'b0;
    in_burst         = 1'b0;
    out_burst        = 1'b0;

    foreach (directed[i]) add_byte(directed[i]);

    while (tx_bytes.size() < 1560) begin
      noisy = ($urandom_range(0, 9) == 0);
      case ($urandom_range(0, 5))
        0:       op = OP_CONT;
        1:       op = OP_TEXT;
        2:       op = OP_BINARY;
        3:       op = OP_CLOSE;
        4:       op = OP_PING;
        default: op = OP_PONG;
      endcase
      if (noisy) op = 4'($urandom_range(0, 15));
      sel = $urandom_range(0, 19);
      if (sel < 12) begin
        form = LEN_DIRECT;
        len  = 64'($urandom_range(0, 12));
      end else if (sel < 15) begin
        form = LEN_DIRECT;
        len  = ($urandom_range(0, 3) == 0) ? 64'd125 : 64'($urandom_range(0, 125));
      end else if (sel < 18) begin
        form = LEN_EXT16;
        len  = 64'($urandom_range(0, 200));
      end else begin
        form = LEN_EXT64;
        len  = 64'($urandom_range(0, 40));
      end
      add_frame(1'($urandom_range(0, 1)), noisy ? 3'($urandom) : 3'd0, op,
                1'($urandom_range(0, 1)), form, len, int'(len), noisy);
    end

    add_frame(1'b1, 3'd0, OP_BINARY, 1'b1, LEN_EXT64, 64'hFFFF_FFFF_FFFF_FFFF, 24, 1'b0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    while (tx_bytes.size() != 0 || stream.valid) @(posedge clk);
    while (expected_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    if (mismatches == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### websocket_frame_deframer.f
hdl/wsd_pkg.sv
hdl/wsd_if.sv
hdl/wsd_stage_in.sv
hdl/wsd_parser.sv
hdl/wsd_result_reg.sv
hdl/websocket_frame_deframer.sv
dv/websocket_frame_deframer_test.sv
